// ===== rtl/core/pocid_pkg.sv =====
// Shared types and constants for the particle octree cell id block.
package pocid_pkg;

	localparam int POS_W      = 32;
	localparam int CELL_ID_W  = 30;
	localparam int LEVELS_W   = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_LEN_X  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_LEN_Y  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_INV_LEN_Z  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_TREE_LEVEL = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_WRAP_EN    = 3'd7;

	localparam logic [POS_W-1:0]    INV_LEN_RESET = 32'd65536;
	localparam logic [LEVELS_W-1:0] LEVELS_RESET  = 4'd4;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} pos_t;

	typedef struct packed {
		logic [CELL_ID_W-1:0] cell_id;
		logic                 outside_box;
	} cell_t;

	typedef struct packed {
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
		logic signed [POS_W-1:0] center_z;
		logic [POS_W-1:0]        inv_len_x;
		logic [POS_W-1:0]        inv_len_y;
		logic [POS_W-1:0]        inv_len_z;
		logic [LEVELS_W-1:0]     tree_levels;
		logic                    wrap_enable;
	} cfg_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_ctl_t;

endpackage

// ===== rtl/core/pocid_cfg.sv =====
// Configuration register file for the particle octree cell id block.
module pocid_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pocid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [pocid_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output pocid_pkg::cfg_t                      cfg
);

	pocid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.center_z    <= '0;
			cfg_q.inv_len_x   <= pocid_pkg::INV_LEN_RESET;
			cfg_q.inv_len_y   <= pocid_pkg::INV_LEN_RESET;
			cfg_q.inv_len_z   <= pocid_pkg::INV_LEN_RESET;
			cfg_q.tree_levels <= pocid_pkg::LEVELS_RESET;
			cfg_q.wrap_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pocid_pkg::REG_CENTER_X:   cfg_q.center_x    <= cfg_wdata;
				pocid_pkg::REG_CENTER_Y:   cfg_q.center_y    <= cfg_wdata;
				pocid_pkg::REG_CENTER_Z:   cfg_q.center_z    <= cfg_wdata;
				pocid_pkg::REG_INV_LEN_X:  cfg_q.inv_len_x   <= cfg_wdata;
				pocid_pkg::REG_INV_LEN_Y:  cfg_q.inv_len_y   <= cfg_wdata;
				pocid_pkg::REG_INV_LEN_Z:  cfg_q.inv_len_z   <= cfg_wdata;
				pocid_pkg::REG_TREE_LEVEL: cfg_q.tree_levels <= cfg_wdata[pocid_pkg::LEVELS_W-1:0];
				pocid_pkg::REG_WRAP_EN:    cfg_q.wrap_enable <= cfg_wdata[0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pocid_axis.sv =====
// One axis: offset, magnitude, scale by reciprocal, round and clamp/wrap to a cell.
module pocid_axis #(
	parameter int FRAC_BITS  = 16,
	parameter int MAX_LEVELS = 11
) (
	input  logic                                  clk,
	input  pocid_pkg::stage_ctl_t                 ctl,
	input  logic signed [pocid_pkg::POS_W-1:0]    pos,
	input  logic signed [pocid_pkg::POS_W-1:0]    center,
	input  logic [pocid_pkg::POS_W-1:0]           inv_len,
	input  logic [$clog2(MAX_LEVELS)-1:0]         lm1,
	input  logic                                  wrap,
	output logic [MAX_LEVELS-2:0]                 coord,
	output logic                                  outside
);

	localparam int PW     = pocid_pkg::POS_W;
	localparam int LM1_W  = $clog2(MAX_LEVELS);
	localparam int CELL_W = MAX_LEVELS - 1;
	localparam int FB2    = 2 * FRAC_BITS;
	localparam int PROD_W = 2 * PW;
	localparam int ACC_W  = PROD_W + 2;
	localparam logic [ACC_W-1:0] HALF     = ACC_W'(1) << (FB2 - 1);
	localparam logic [LM1_W-1:0] CELL_W_V = LM1_W'(CELL_W);

	logic [PW:0]         d_s2;
	logic                negd_s3;
	logic [PW-1:0]       mag_s3;
	logic                negd_s4;
	logic [PROD_W-1:0]   prod_s4;
	logic [PROD_W-1:0]   prod_next;
	logic [PW-1:0]       mag_next;
	logic [ACC_W-1:0]    op;
	logic [ACC_W-1:0]    addend;
	logic [ACC_W-1:0]    acc;
	logic                neg;
	logic                big;
	logic [CELL_W-1:0]   top_bits;
	logic [CELL_W-1:0]   cell_raw;
	logic [CELL_W-1:0]   mask;
	logic [LM1_W-1:0]    sh;

	assign mag_next  = d_s2[PW] ? (~d_s2[PW-1:0] + PW'(1)) : d_s2[PW-1:0];
	assign prod_next = mag_s3 * inv_len;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			d_s2 <= {pos[PW-1], pos} - {center[PW-1], center};
		end
		if (ctl.ld_s3) begin
			negd_s3 <= d_s2[PW];
			mag_s3  <= mag_next;
		end
		if (ctl.ld_s4) begin
			negd_s4 <= negd_s3;
			prod_s4 <= prod_next;
		end
	end

	// signed product plus one half; negation folded into the same adder
	always_comb begin
		op     = negd_s4 ? {2'b11, ~prod_s4} : {2'b00, prod_s4};
		addend = negd_s4 ? (HALF + ACC_W'(1)) : HALF;
		acc    = op + addend;
		neg    = acc[ACC_W-1];
		big    = !neg && (|acc[ACC_W-2:FB2]);
		top_bits = acc[FB2-1 -: CELL_W];
		sh       = CELL_W_V - lm1;
		cell_raw = top_bits >> sh;
		mask     = ~({CELL_W{1'b1}} << lm1);
	end

	assign outside = neg || big;
	assign coord   = (outside && !wrap) ? (neg ? '0 : mask) : cell_raw;

endmodule

// ===== rtl/core/particle_octree_cell_id.sv =====
// Top level of the particle octree cell id block.
//
// Input channel pos (pos_valid/pos_ready) carries one particle position per
// transaction; output channel leaf (cell_valid/cell_ready) returns one Morton
// leaf cell id and an outside_box flag per position, in input order.
// Registers are written through cfg_we/cfg_addr/cfg_wdata, one per cycle.
// Write only while no transaction is in flight; the block does not enforce it.
//
// Five-stage pipeline: input register, offset, magnitude, 32x32 product,
// round/clamp/interleave into the output register. Throughput is one position
// per cycle while cell_ready is high.
// When cell_ready is low, each stage holds its item only once the stage after
// it is full; empty stages still take new positions, so pos_ready drops only
// when all five stages are occupied.
// Reset clears all stage valid bits and loads register defaults.
module particle_octree_cell_id #(
	parameter int MAX_LEVELS = 11,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pos_valid,
	output logic                                pos_ready,
	input  pocid_pkg::pos_t                     pos,
	output logic                                cell_valid,
	input  logic                                cell_ready,
	output pocid_pkg::cell_t                    leaf,
	input  logic                                cfg_we,
	input  logic [pocid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [pocid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int LM1_W  = $clog2(MAX_LEVELS);
	localparam int CELL_W = MAX_LEVELS - 1;
	localparam int LW     = pocid_pkg::LEVELS_W;

	pocid_pkg::cfg_t       cfg;
	pocid_pkg::stage_ctl_t ctl;
	pocid_pkg::pos_t       pos_s1;
	pocid_pkg::cell_t      cell_s5;
	pocid_pkg::cell_t      cell_next;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                  free1, free2, free3, free4, free5;
	logic [LW-1:0]         lvl;
	logic [LW-1:0]         lvl_m1;
	logic [LM1_W-1:0]      lm1;
	logic [CELL_W-1:0]     cx, cy, cz;
	logic                  ox, oy, oz;

	pocid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign free5 = !v_s5 || cell_ready;
	assign free4 = !v_s4 || free5;
	assign free3 = !v_s3 || free4;
	assign free2 = !v_s2 || free3;
	assign free1 = !v_s1 || free2;

	assign pos_ready = free1;
	assign ctl       = {free2, free3, free4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (free1) v_s1 <= pos_valid;
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
			if (free5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free1) pos_s1  <= pos;
		if (free5) cell_s5 <= cell_next;
	end

	always_comb begin
		lvl = cfg.tree_levels;
		if (lvl == '0) begin
			lvl = LW'(1);
		end else if (lvl > LW'(MAX_LEVELS)) begin
			lvl = LW'(MAX_LEVELS);
		end
		lvl_m1 = lvl - LW'(1);
	end

	assign lm1 = lvl_m1[LM1_W-1:0];

	pocid_axis #(.FRAC_BITS(FRAC_BITS), .MAX_LEVELS(MAX_LEVELS)) u_axis_x (
		.clk (clk), .ctl (ctl), .pos (pos_s1.pos_x), .center (cfg.center_x),
		.inv_len (cfg.inv_len_x), .lm1 (lm1), .wrap (cfg.wrap_enable),
		.coord (cx), .outside (ox)
	);

	pocid_axis #(.FRAC_BITS(FRAC_BITS), .MAX_LEVELS(MAX_LEVELS)) u_axis_y (
		.clk (clk), .ctl (ctl), .pos (pos_s1.pos_y), .center (cfg.center_y),
		.inv_len (cfg.inv_len_y), .lm1 (lm1), .wrap (cfg.wrap_enable),
		.coord (cy), .outside (oy)
	);

	pocid_axis #(.FRAC_BITS(FRAC_BITS), .MAX_LEVELS(MAX_LEVELS)) u_axis_z (
		.clk (clk), .ctl (ctl), .pos (pos_s1.pos_z), .center (cfg.center_z),
		.inv_len (cfg.inv_len_z), .lm1 (lm1), .wrap (cfg.wrap_enable),
		.coord (cz), .outside (oz)
	);

	// Morton interleave: x -> 3k, y -> 3k+1, z -> 3k+2
	always_comb begin
		cell_next = '0;
		for (int k = 0; k < CELL_W; k++) begin
			cell_next.cell_id[3*k]   = cx[k];
			cell_next.cell_id[3*k+1] = cy[k];
			cell_next.cell_id[3*k+2] = cz[k];
		end
		cell_next.outside_box = ox || oy || oz;
	end

	assign cell_valid = v_s5;
	assign leaf       = cell_s5;

endmodule

// ===== rtl/core/pocid_checker.sv =====
// Port-level checks for the particle octree cell id block, bound to the top level.
module pocid_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                pos_ready,
	input logic                                cell_valid,
	input logic                                cell_ready,
	input pocid_pkg::cell_t                    leaf
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_ready |=> cell_valid)
		else $error("cell_valid dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_ready |=> $stable(leaf))
		else $error("cell payload changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_valid |-> pos_ready)
		else $error("pos_ready low with empty output");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !cell_valid)
		else $error("cell_valid set right after reset");

endmodule

bind particle_octree_cell_id pocid_checker u_pocid_checker (.*);

// ===== verif/cell_id_checker.sv =====
`timescale 1ns / 100ps
// Checker for particle_octree_cell_id: tracks registers, predicts cell ids, compares results.
module cell_id_checker #(
	parameter int MAX_LEVELS = 11,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pos_valid,
	input  logic                                pos_ready,
	input  pocid_pkg::pos_t                     pos,
	input  logic                                cell_valid,
	input  logic                                cell_ready,
	input  pocid_pkg::cell_t                    leaf,
	input  logic                                cfg_we,
	input  logic [pocid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [pocid_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output int                                  errors,
	output int                                  pending
);

	localparam int COORD_W = MAX_LEVELS - 1;
	localparam logic signed [67:0] HALF = 68'sd1 <<< (2 * FRAC_BITS - 1);

	typedef struct {
		pocid_pkg::pos_t  p;
		pocid_pkg::cell_t c;
	} cell_due_t;

	pocid_pkg::cfg_t regs;
	cell_due_t       cells_due[$];
	int              printed;

	task automatic report_mismatch(input string what);
		errors++;
		if (printed < 40) begin
			printed++;
			$display("cell_id_checker: %s @ %0t", what, $realtime);
		end
	endtask

	// cell coordinate of one axis; flags clamping or wrapping
	function automatic logic [COORD_W-1:0] axis_cell(input logic signed [31:0] p,
			input logic signed [31:0] c, input logic [31:0] inv, input int lm1,
			input logic wrap, output logic clipped);
		logic signed [67:0] diff, prod, q, lim;
		diff = p - c;
		prod = diff * $signed({36'd0, inv});
		q = (prod + HALF) >>> (2 * FRAC_BITS - lm1);
		lim = (68'sd1 <<< lm1) - 68'sd1;
		clipped = 1'b0;
		if (q < 0 || q > lim) begin
			clipped = 1'b1;
			if (wrap)
				return q[COORD_W-1:0] & lim[COORD_W-1:0];
			return (q < 0) ? '0 : lim[COORD_W-1:0];
		end
		return q[COORD_W-1:0];
	endfunction

	function automatic pocid_pkg::cell_t predict_cell(input pocid_pkg::pos_t p);
		pocid_pkg::cell_t r;
		int lvl, lm1;
		logic [COORD_W-1:0] cx, cy, cz;
		logic ox, oy, oz;
		lvl = regs.tree_levels;
		if (lvl < 1)
			lvl = 1;
		if (lvl > MAX_LEVELS)
			lvl = MAX_LEVELS;
		lm1 = lvl - 1;
		cx = axis_cell(p.pos_x, regs.center_x, regs.inv_len_x, lm1, regs.wrap_enable, ox);
		cy = axis_cell(p.pos_y, regs.center_y, regs.inv_len_y, lm1, regs.wrap_enable, oy);
		cz = axis_cell(p.pos_z, regs.center_z, regs.inv_len_z, lm1, regs.wrap_enable, oz);
		r.cell_id = '0;
		for (int k = 0; k < lm1; k++) begin
			r.cell_id[3*k]   = cx[k];
			r.cell_id[3*k+1] = cy[k];
			r.cell_id[3*k+2] = cz[k];
		end
		r.outside_box = ox | oy | oz;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_due_t want;
		if (!arst_n) begin
			regs = '0;
			regs.inv_len_x = pocid_pkg::INV_LEN_RESET;
			regs.inv_len_y = pocid_pkg::INV_LEN_RESET;
			regs.inv_len_z = pocid_pkg::INV_LEN_RESET;
			regs.tree_levels = pocid_pkg::LEVELS_RESET;
			cells_due.delete();
		end else begin
			if (cell_valid && cell_ready) begin
				if (cells_due.size() == 0) begin
					report_mismatch($sformatf("cell transaction with none due: id %h out %b",
						leaf.cell_id, leaf.outside_box));
				end else begin
					want = cells_due.pop_front();
					if (leaf.cell_id !== want.c.cell_id)
						report_mismatch($sformatf("pos %h/%h/%h cell_id %h, want %h",
							want.p.pos_x, want.p.pos_y, want.p.pos_z,
							leaf.cell_id, want.c.cell_id));
					if (leaf.outside_box !== want.c.outside_box)
						report_mismatch($sformatf("pos %h/%h/%h outside_box %b, want %b",
							want.p.pos_x, want.p.pos_y, want.p.pos_z,
							leaf.outside_box, want.c.outside_box));
				end
			end
			if (pos_valid && pos_ready) begin
				want.p = pos;
				want.c = predict_cell(pos);
				cells_due.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_addr)
					pocid_pkg::REG_CENTER_X:   regs.center_x = cfg_wdata;
					pocid_pkg::REG_CENTER_Y:   regs.center_y = cfg_wdata;
					pocid_pkg::REG_CENTER_Z:   regs.center_z = cfg_wdata;
					pocid_pkg::REG_INV_LEN_X:  regs.inv_len_x = cfg_wdata;
					pocid_pkg::REG_INV_LEN_Y:  regs.inv_len_y = cfg_wdata;
					pocid_pkg::REG_INV_LEN_Z:  regs.inv_len_z = cfg_wdata;
					pocid_pkg::REG_TREE_LEVEL:
						regs.tree_levels = cfg_wdata[pocid_pkg::LEVELS_W-1:0];
					pocid_pkg::REG_WRAP_EN:    regs.wrap_enable = cfg_wdata[0];
					default: ;
				endcase
			end
		end
		pending = cells_due.size();
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for particle_octree_cell_id: clock, reset, stimulus and verdict.
module testbench;

	localparam int MAX_LEVELS = 11;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 104;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             pos_valid = 1'b0;
	logic                             pos_ready;
	pocid_pkg::pos_t                  pos = '0;
	logic                             cell_valid;
	logic                             cell_ready = 1'b0;
	pocid_pkg::cell_t                 leaf;
	logic                             cfg_we = 1'b0;
	logic [pocid_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [pocid_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	int mismatches;
	int cells_pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	particle_octree_cell_id #(
		.MAX_LEVELS (MAX_LEVELS),
		.FRAC_BITS  (FRAC_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pos_valid  (pos_valid),
		.pos_ready  (pos_ready),
		.pos        (pos),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.leaf       (leaf),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata)
	);

	cell_id_checker #(
		.MAX_LEVELS (MAX_LEVELS),
		.FRAC_BITS  (FRAC_BITS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pos_valid  (pos_valid),
		.pos_ready  (pos_ready),
		.pos        (pos),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.leaf       (leaf),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.errors     (mismatches),
		.pending    (cells_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(2_000_000);
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				cell_ready <= 1'b0;
			end else begin
				cell_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER) ? 72 : (mode == IDLE_BOTH) ? 27 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 72 : (mode == IDLE_BOTH) ? 27 : 0;
	endtask

	task automatic send_pos(input pocid_pkg::pos_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pos_valid <= 1'b0;
			@(posedge clk);
		end
		pos_valid <= 1'b1;
		pos <= p;
		@(posedge clk);
		while (!pos_ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every due cell has come back
	task automatic drain(input int tail);
		pos_valid <= 1'b0;
		@(posedge clk);
		while (cells_pending != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pocid_pkg::CFG_ADDR_W-1:0] idx,
			input logic [pocid_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic apply_config(input pocid_pkg::cfg_t c);
		write_reg(pocid_pkg::REG_CENTER_X, c.center_x);
		write_reg(pocid_pkg::REG_CENTER_Y, c.center_y);
		write_reg(pocid_pkg::REG_CENTER_Z, c.center_z);
		write_reg(pocid_pkg::REG_INV_LEN_X, c.inv_len_x);
		write_reg(pocid_pkg::REG_INV_LEN_Y, c.inv_len_y);
		write_reg(pocid_pkg::REG_INV_LEN_Z, c.inv_len_z);
		write_reg(pocid_pkg::REG_TREE_LEVEL, {28'($urandom), c.tree_levels});
		write_reg(pocid_pkg::REG_WRAP_EN, {31'($urandom), c.wrap_enable});
		cfg_we <= 1'b0;
	endtask

	function automatic pocid_pkg::cfg_t reset_config();
		pocid_pkg::cfg_t c;
		c = '0;
		c.inv_len_x = pocid_pkg::INV_LEN_RESET;
		c.inv_len_y = pocid_pkg::INV_LEN_RESET;
		c.inv_len_z = pocid_pkg::INV_LEN_RESET;
		c.tree_levels = pocid_pkg::LEVELS_RESET;
		return c;
	endfunction

	function automatic pocid_pkg::cfg_t pick_config(input int ph);
		pocid_pkg::cfg_t c;
		c.center_x = $urandom;
		c.center_y = $urandom;
		c.center_z = $urandom;
		c.inv_len_x = $urandom >> $urandom_range(31);
		c.inv_len_y = $urandom >> $urandom_range(31);
		c.inv_len_z = $urandom >> $urandom_range(31);
		c.tree_levels = 4'($urandom_range(1, MAX_LEVELS));
		c.wrap_enable = 1'($urandom_range(1));
		case (ph % 6)
			1: begin
				c.tree_levels = 4'(MAX_LEVELS);
				c.wrap_enable = 1'b1;
			end
			2: c.tree_levels = 4'd1;
			3: begin
				c.center_x = 32'h8000_0000;
				c.center_y = 32'h8000_0000;
				c.center_z = 32'h8000_0000;
				c.inv_len_x = 32'hFFFF_FFFF;
				c.inv_len_y = 32'hFFFF_FFFF;
				c.inv_len_z = 32'hFFFF_FFFF;
			end
			4: begin
				c.center_x = 32'h7FFF_FFFF;
				c.center_y = 32'h7FFF_FFFF;
				c.center_z = 32'h7FFF_FFFF;
				c.inv_len_x = '0;
			end
			5: c.tree_levels = (ph < 6) ? 4'd0 : 4'd15;
			default: ;
		endcase
		return c;
	endfunction

	// mostly within about one box edge of the center, some anywhere
	function automatic logic [31:0] pick_coord(input logic [31:0] c, input logic [31:0] inv);
		logic [63:0] span;
		logic [31:0] off;
		if ($urandom_range(99) < 15)
			return $urandom;
		span = (inv == '0) ? 64'h8000_0000 : 64'h1_0000_0000 / inv + 64'd1;
		if (span > 64'h8000_0000)
			span = 64'h8000_0000;
		off = $urandom_range(span[31:0]);
		if ($urandom_range(1) == 1)
			off = -off;
		return c + off;
	endfunction

	initial begin
		pocid_pkg::cfg_t c;
		pocid_pkg::pos_t p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: 8 cells per edge, unit box at the origin
		set_idling(IDLE_NONE);
		send_pos(pocid_pkg::pos_t'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_pos(pocid_pkg::pos_t'{32'hFFFF_8000, 32'hFFFF_7FFF, 32'h0000_7FFF});
		send_pos(pocid_pkg::pos_t'{32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000});
		send_pos(pocid_pkg::pos_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_pos(pocid_pkg::pos_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_pos(pocid_pkg::pos_t'{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_4000});
		drain(6);

		// levels zero acts as one, wrap mode
		c = reset_config();
		c.tree_levels = 4'd0;
		c.wrap_enable = 1'b1;
		c.center_x = 32'h7FFF_FFFF;
		c.inv_len_x = 32'hFFFF_FFFF;
		apply_config(c);
		send_pos(pocid_pkg::pos_t'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000});
		send_pos(pocid_pkg::pos_t'{32'h8000_0000, 32'h0000_8000, 32'hFFFF_7FFF});
		drain(6);

		// levels above the maximum act as the maximum
		c = reset_config();
		c.tree_levels = 4'd15;
		apply_config(c);
		send_pos(pocid_pkg::pos_t'{32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_0000});
		send_pos(pocid_pkg::pos_t'{32'h0000_8000, 32'hFFFF_7FFF, 32'h7FFF_FFFF});
		drain(6);

		// single level
		c = reset_config();
		c.tree_levels = 4'd1;
		apply_config(c);
		send_pos(pocid_pkg::pos_t'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
		send_pos(pocid_pkg::pos_t'{32'h0000_0000, 32'h0001_0000, 32'h0000_0000});
		drain(6);

		// zero reciprocal gives the middle cell
		c = reset_config();
		c.tree_levels = 4'(MAX_LEVELS);
		c.inv_len_x = '0;
		c.inv_len_y = '0;
		c.inv_len_z = '0;
		apply_config(c);
		send_pos(pocid_pkg::pos_t'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000});
		send_pos(pocid_pkg::pos_t'{32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001});
		drain(6);

		// deepest tree, wrap, steepest scale, lowest center
		c.wrap_enable = 1'b1;
		c.inv_len_x = 32'hFFFF_FFFF;
		c.inv_len_y = 32'hFFFF_FFFF;
		c.inv_len_z = 32'hFFFF_FFFF;
		c.center_x = 32'h8000_0000;
		c.center_y = 32'h8000_0000;
		c.center_z = 32'h8000_0000;
		apply_config(c);
		send_pos(pocid_pkg::pos_t'{32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF});
		send_pos(pocid_pkg::pos_t'{32'h8000_7FFF, 32'h8000_8000, 32'hFFFF_FFFF});
		send_pos(pocid_pkg::pos_t'{32'h0000_0000, 32'h8000_0000, 32'h8000_0000});
		drain(6);

		// two levels, wrap, highest center
		c = reset_config();
		c.tree_levels = 4'd2;
		c.wrap_enable = 1'b1;
		c.center_x = 32'h7FFF_FFFF;
		c.center_y = 32'h7FFF_FFFF;
		c.center_z = 32'h7FFF_FFFF;
		apply_config(c);
		send_pos(pocid_pkg::pos_t'{32'h7FFF_FFFF, 32'h7FFF_7FFF, 32'h8000_0000});
		send_pos(pocid_pkg::pos_t'{32'h7FFF_8000, 32'h7FFE_FFFF, 32'h7FFF_0000});
		send_pos(pocid_pkg::pos_t'{32'h0000_0000, 32'h7FFF_FFFE, 32'h7FFF_C000});
		drain(6);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_idling(idle_mode_t'(ph % 4));
			c = pick_config(ph);
			apply_config(c);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 20)
					hold_left = 48;
				if (ph == 4 && n == 50)
					drain(0);
				p.pos_x = pick_coord(c.center_x, c.inv_len_x);
				p.pos_y = pick_coord(c.center_y, c.inv_len_y);
				p.pos_z = pick_coord(c.center_z, c.inv_len_z);
				send_pos(p);
			end
			drain(6);
		end

		if (mismatches == 0 && cells_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pocid_pkg.sv
rtl/core/pocid_cfg.sv
rtl/core/pocid_axis.sv
rtl/core/particle_octree_cell_id.sv
rtl/core/pocid_checker.sv
verif/cell_id_checker.sv
verif/testbench.sv
